// ===== design/rhpc_pkg.sv =====
// rhpc_pkg: shared types, constants and the boot logo table for the rom header patcher
// no dependencies; used by every module of the block by scoped names

package rhpc_pkg;

	localparam int ADDR_BITS = 24;

	// header addresses
	localparam logic [ADDR_BITS-1:0] ADDR_LOGO_LO  = ADDR_BITS'('h104);
	localparam logic [ADDR_BITS-1:0] ADDR_LOGO_HI  = ADDR_BITS'('h134);
	localparam logic [ADDR_BITS-1:0] ADDR_CGB      = ADDR_BITS'('h143);
	localparam logic [ADDR_BITS-1:0] ADDR_NEWLIC_H = ADDR_BITS'('h144);
	localparam logic [ADDR_BITS-1:0] ADDR_NEWLIC_L = ADDR_BITS'('h145);
	localparam logic [ADDR_BITS-1:0] ADDR_SGB      = ADDR_BITS'('h146);
	localparam logic [ADDR_BITS-1:0] ADDR_CART     = ADDR_BITS'('h147);
	localparam logic [ADDR_BITS-1:0] ADDR_ROMSIZE  = ADDR_BITS'('h148);
	localparam logic [ADDR_BITS-1:0] ADDR_RAMSIZE  = ADDR_BITS'('h149);
	localparam logic [ADDR_BITS-1:0] ADDR_REGION   = ADDR_BITS'('h14A);
	localparam logic [ADDR_BITS-1:0] ADDR_OLDLIC   = ADDR_BITS'('h14B);
	localparam logic [ADDR_BITS-1:0] ADDR_VERSION  = ADDR_BITS'('h14C);
	localparam logic [ADDR_BITS-1:0] ADDR_HDRSUM   = ADDR_BITS'('h14D);
	localparam logic [ADDR_BITS-1:0] ADDR_GSUM_H   = ADDR_BITS'('h14E);
	localparam logic [ADDR_BITS-1:0] ADDR_GSUM_L   = ADDR_BITS'('h14F);
	localparam logic [ADDR_BITS-1:0] ADDR_HDR_LO   = ADDR_BITS'('h134);
	localparam logic [ADDR_BITS-1:0] ADDR_MAX      = {ADDR_BITS{1'b1}};

	localparam logic [7:0] SGB_VALUE    = 8'h03;
	localparam logic [7:0] REGION_VALUE = 8'h01;
	localparam logic [7:0] CGB_COMPAT   = 8'h80;
	localparam logic [7:0] CGB_ONLY     = 8'h40;
	localparam logic [7:0] LOW_SIX_MASK = 8'h3F;

	// mode codes; code three behaves as off
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_PLAIN = 2'd1;
	localparam logic [1:0] MODE_INV   = 2'd2;

	// image status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_SAT   = 2'd2;

	// register indexes
	localparam logic [2:0] REG_LOGO_MODE   = 3'd0;
	localparam logic [2:0] REG_HDRSUM_MODE = 3'd1;
	localparam logic [2:0] REG_GSUM_MODE   = 3'd2;
	localparam logic [2:0] REG_FLAG_BITS   = 3'd3;
	localparam logic [2:0] REG_OVR_ENABLE  = 3'd4;
	localparam logic [2:0] REG_OVR_BYTES   = 3'd5;
	localparam logic [2:0] REG_NEW_LIC     = 3'd6;
	localparam logic [2:0] REG_ROM_SIZE    = 3'd7;

	localparam int PADDR_BITS = 5;

	typedef struct packed {
		logic [1:0]  logo_mode;
		logic [1:0]  header_sum_mode;
		logic [1:0]  global_sum_mode;
		logic [3:0]  flag_bits;
		logic [5:0]  override_enable;
		logic [31:0] override_bytes;
		logic [15:0] new_licensee_code;
		logic [7:0]  rom_size_code;
	} cfg_t;

	function automatic logic [7:0] logo_byte(input logic [5:0] idx);
		logic [7:0] v;
		unique case (idx)
			6'd0:  v = 8'hCE; 6'd1:  v = 8'hED; 6'd2:  v = 8'h66; 6'd3:  v = 8'h66;
			6'd4:  v = 8'hCC; 6'd5:  v = 8'h0D; 6'd6:  v = 8'h00; 6'd7:  v = 8'h0B;
			6'd8:  v = 8'h03; 6'd9:  v = 8'h73; 6'd10: v = 8'h00; 6'd11: v = 8'h83;
			6'd12: v = 8'h00; 6'd13: v = 8'h0C; 6'd14: v = 8'h00; 6'd15: v = 8'h0D;
			6'd16: v = 8'h00; 6'd17: v = 8'h08; 6'd18: v = 8'h11; 6'd19: v = 8'h1F;
			6'd20: v = 8'h88; 6'd21: v = 8'h89; 6'd22: v = 8'h00; 6'd23: v = 8'h0E;
			6'd24: v = 8'hDC; 6'd25: v = 8'hCC; 6'd26: v = 8'h6E; 6'd27: v = 8'hE6;
			6'd28: v = 8'hDD; 6'd29: v = 8'hDD; 6'd30: v = 8'hD9; 6'd31: v = 8'h99;
			6'd32: v = 8'hBB; 6'd33: v = 8'hBB; 6'd34: v = 8'h67; 6'd35: v = 8'h63;
			6'd36: v = 8'h6E; 6'd37: v = 8'h0E; 6'd38: v = 8'hEC; 6'd39: v = 8'hCC;
			6'd40: v = 8'hDD; 6'd41: v = 8'hDC; 6'd42: v = 8'h99; 6'd43: v = 8'h9F;
			6'd44: v = 8'hBB; 6'd45: v = 8'hB9; 6'd46: v = 8'h33; 6'd47: v = 8'h3E;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== design/rom_header_patch_checksum_top.sv =====
// rom_header_patch_checksum_top: streaming rom header patcher with header and global sums
// depends on rhpc_pkg, rhpc_cfg_regs and rhpc_patch
// each byte passes through the input stage and then the result register
// throughput: one byte per cycle; both stages advance together when the result register frees
// the address counter, header sum and running sum update as a byte moves into the result register
// reset (arst_n low): both stages empty, stream state and config registers cleared to zero; payload regs not reset

module rom_header_patch_checksum_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rom_byte
	input  logic                            s_tlast,   // final_byte
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // [7:0] patched_byte, [23:8] global_sum,
	                                                   // [24] sum_valid, [25] colour_conflict,
	                                                   // [27:26] image_status, [31:28] zero
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rhpc_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	rhpc_pkg::cfg_t cfg;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result stage
	logic        valid_s2;
	logic [31:0] data_s2;

	// per-image stream state
	logic [rhpc_pkg::ADDR_BITS-1:0] addr_q;
	logic [7:0]                     hdr_sum_q;
	logic [15:0]                    run_sum_q;
	logic                           sat_q;

	// datapath
	logic        advance;
	logic        step;
	logic [7:0]  patched;
	logic        conflict;
	logic        in_hdr;
	logic        in_gsum;
	logic        at_max;
	logic [7:0]  hdr_sum_nx;
	logic [15:0] run_sum_nx;
	logic        sat_nx;
	logic [15:0] gsum;
	logic        gsum_valid;
	logic [1:0]  status;

	rhpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rhpc_patch u_patch (
		.addr       (addr_q),
		.byte_in    (byte_s1),
		.cfg        (cfg),
		.header_sum (hdr_sum_q),
		.byte_out   (patched),
		.conflict   (conflict)
	);

	// pipeline moves whenever the result register is empty or being drained
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// checksum and counter logic for the byte in the input stage
	assign in_hdr     = (addr_q >= rhpc_pkg::ADDR_HDR_LO) && (addr_q < rhpc_pkg::ADDR_HDRSUM);
	assign in_gsum    = (addr_q == rhpc_pkg::ADDR_GSUM_H) || (addr_q == rhpc_pkg::ADDR_GSUM_L);
	assign at_max     = (addr_q == rhpc_pkg::ADDR_MAX);
	assign hdr_sum_nx = in_hdr ? (hdr_sum_q - patched - 8'd1) : hdr_sum_q;
	assign run_sum_nx = in_gsum ? run_sum_q : (run_sum_q + {8'd0, patched});
	assign sat_nx     = sat_q | at_max;

	always_comb begin
		gsum       = 16'd0;
		gsum_valid = 1'b0;
		status     = rhpc_pkg::STATUS_OK;
		if (last_s1) begin
			if (cfg.global_sum_mode == rhpc_pkg::MODE_PLAIN) begin
				gsum       = run_sum_nx;
				gsum_valid = 1'b1;
			end else if (cfg.global_sum_mode == rhpc_pkg::MODE_INV) begin
				gsum       = ~run_sum_nx;
				gsum_valid = 1'b1;
			end
			// saturation outranks a short image
			if (sat_nx) begin
				status = rhpc_pkg::STATUS_SAT;
			end else if (addr_q < rhpc_pkg::ADDR_GSUM_L) begin
				status = rhpc_pkg::STATUS_SHORT;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			addr_q    <= '0;
			hdr_sum_q <= '0;
			run_sum_q <= '0;
			sat_q     <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (step) begin
				if (last_s1) begin
					// end of image: next image starts afresh
					addr_q    <= '0;
					hdr_sum_q <= '0;
					run_sum_q <= '0;
					sat_q     <= 1'b0;
				end else begin
					hdr_sum_q <= hdr_sum_nx;
					run_sum_q <= run_sum_nx;
					sat_q     <= sat_nx;
					if (!at_max) begin
						addr_q <= addr_q + 1'b1;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (step) begin
			data_s2 <= {4'd0, status, conflict, gsum_valid, gsum, patched};
		end
	end

endmodule

// ===== design/rhpc_cfg_regs.sv =====
// rhpc_cfg_regs: apb-style register file holding the patch configuration
// depends on rhpc_pkg

module rhpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rhpc_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output rhpc_pkg::cfg_t                 cfg
);

	rhpc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[rhpc_pkg::PADDR_BITS-1:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				rhpc_pkg::REG_LOGO_MODE:   cfg_q.logo_mode         <= pwdata[1:0];
				rhpc_pkg::REG_HDRSUM_MODE: cfg_q.header_sum_mode   <= pwdata[1:0];
				rhpc_pkg::REG_GSUM_MODE:   cfg_q.global_sum_mode   <= pwdata[1:0];
				rhpc_pkg::REG_FLAG_BITS:   cfg_q.flag_bits         <= pwdata[3:0];
				rhpc_pkg::REG_OVR_ENABLE:  cfg_q.override_enable   <= pwdata[5:0];
				rhpc_pkg::REG_OVR_BYTES:   cfg_q.override_bytes    <= pwdata;
				rhpc_pkg::REG_NEW_LIC:     cfg_q.new_licensee_code <= pwdata[15:0];
				rhpc_pkg::REG_ROM_SIZE:    cfg_q.rom_size_code     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			rhpc_pkg::REG_LOGO_MODE:   prdata = {30'd0, cfg_q.logo_mode};
			rhpc_pkg::REG_HDRSUM_MODE: prdata = {30'd0, cfg_q.header_sum_mode};
			rhpc_pkg::REG_GSUM_MODE:   prdata = {30'd0, cfg_q.global_sum_mode};
			rhpc_pkg::REG_FLAG_BITS:   prdata = {28'd0, cfg_q.flag_bits};
			rhpc_pkg::REG_OVR_ENABLE:  prdata = {26'd0, cfg_q.override_enable};
			rhpc_pkg::REG_OVR_BYTES:   prdata = cfg_q.override_bytes;
			rhpc_pkg::REG_NEW_LIC:     prdata = {16'd0, cfg_q.new_licensee_code};
			rhpc_pkg::REG_ROM_SIZE:    prdata = {24'd0, cfg_q.rom_size_code};
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== design/rhpc_patch.sv =====
// rhpc_patch: address-decoded byte substitution for the header area
// depends on rhpc_pkg

module rhpc_patch (
	input  logic [rhpc_pkg::ADDR_BITS-1:0] addr,
	input  logic [7:0]                     byte_in,
	input  rhpc_pkg::cfg_t                 cfg,
	input  logic [7:0]                     header_sum,
	output logic [7:0]                     byte_out,
	output logic                           conflict
);

	logic                          in_logo;
	logic [rhpc_pkg::ADDR_BITS-1:0] logo_off;
	logic [7:0]                    logo_val;
	logic                          colour;
	logic [7:0]                    cgb_val;

	assign in_logo  = (addr >= rhpc_pkg::ADDR_LOGO_LO) && (addr < rhpc_pkg::ADDR_LOGO_HI);
	assign logo_off = addr - rhpc_pkg::ADDR_LOGO_LO;
	assign logo_val = rhpc_pkg::logo_byte(logo_off[5:0]);
	assign colour   = |cfg.flag_bits[1:0];
	assign cgb_val  = byte_in | rhpc_pkg::CGB_COMPAT
		| (cfg.flag_bits[1] ? rhpc_pkg::CGB_ONLY : 8'h00);

	always_comb begin
		byte_out = byte_in;
		conflict = 1'b0;
		if (in_logo) begin
			if (cfg.logo_mode == rhpc_pkg::MODE_PLAIN) begin
				byte_out = logo_val;
			end else if (cfg.logo_mode == rhpc_pkg::MODE_INV) begin
				byte_out = ~logo_val;
			end
		end else begin
			unique case (addr)
				rhpc_pkg::ADDR_CGB: begin
					if (colour) begin
						byte_out = cgb_val;
						conflict = |(byte_in & rhpc_pkg::LOW_SIX_MASK);
					end
				end
				rhpc_pkg::ADDR_NEWLIC_H:
					if (cfg.override_enable[0]) byte_out = cfg.new_licensee_code[15:8];
				rhpc_pkg::ADDR_NEWLIC_L:
					if (cfg.override_enable[0]) byte_out = cfg.new_licensee_code[7:0];
				rhpc_pkg::ADDR_SGB:
					if (cfg.flag_bits[2]) byte_out = rhpc_pkg::SGB_VALUE;
				rhpc_pkg::ADDR_CART:
					if (cfg.override_enable[1]) byte_out = cfg.override_bytes[7:0];
				rhpc_pkg::ADDR_ROMSIZE:
					if (cfg.override_enable[2]) byte_out = cfg.rom_size_code;
				rhpc_pkg::ADDR_RAMSIZE:
					if (cfg.override_enable[3]) byte_out = cfg.override_bytes[15:8];
				rhpc_pkg::ADDR_REGION:
					if (cfg.flag_bits[3]) byte_out = rhpc_pkg::REGION_VALUE;
				rhpc_pkg::ADDR_OLDLIC:
					if (cfg.override_enable[4]) byte_out = cfg.override_bytes[23:16];
				rhpc_pkg::ADDR_VERSION:
					if (cfg.override_enable[5]) byte_out = cfg.override_bytes[31:24];
				rhpc_pkg::ADDR_HDRSUM: begin
					if (cfg.header_sum_mode == rhpc_pkg::MODE_PLAIN) begin
						byte_out = header_sum;
					end else if (cfg.header_sum_mode == rhpc_pkg::MODE_INV) begin
						byte_out = ~header_sum;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== bench/rom_header_patch_checksum_top_test.sv =====
// rom_header_patch_checksum_top_test: self-checking bench for the streaming rom header patcher
// needs rhpc_pkg and rom_header_patch_checksum_top; predicts every patched byte, sum and status

module rom_header_patch_checksum_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	// mode code three is left undefined by the block and must act as off
	localparam logic [1:0] MODE_THREE = 2'd3;

	// flag_bits positions
	localparam int FLAG_COMPAT = 0;
	localparam int FLAG_ONLY   = 1;
	localparam int FLAG_SGB    = 2;
	localparam int FLAG_REGION = 3;

	// override_enable positions
	localparam int OVR_NEWLIC  = 0;
	localparam int OVR_CART    = 1;
	localparam int OVR_ROMSIZE = 2;
	localparam int OVR_RAMSIZE = 3;
	localparam int OVR_OLDLIC  = 4;
	localparam int OVR_VERSION = 5;

	localparam int PHASES = 8;

	// boot logo as it must appear at 0x104-0x133
	localparam logic [0:47][7:0] BOOT_LOGO = {
		8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
		8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
		8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
		8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
		8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
		8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
	};

	// one input transaction: rom byte plus end-of-image mark
	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} rom_item_t;

	// one result transaction, laid out as m_tdata[27:0]
	typedef struct packed {
		logic [1:0]  status;
		logic        conflict;
		logic        sum_ok;
		logic [15:0] gsum;
		logic [7:0]  patched;
	} patched_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] rom_byte
	logic        s_tlast = 1'b0;  // final_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [7:0] patched_byte, [23:8] global_sum, [24] sum_valid,
	                              // [25] colour_conflict, [27:26] image_status, [31:28] zero
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [rhpc_pkg::PADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	rom_header_patch_checksum_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// register copy as the block should hold it
	rhpc_pkg::cfg_t live_cfg = '0;

	// image state mirrored from the block
	logic [rhpc_pkg::ADDR_BITS-1:0] rom_addr = '0;
	logic [7:0]                     hdr_sum = '0;
	logic [15:0]                    img_sum = '0;
	logic                           img_sat = 1'b0;

	rom_item_t rom_q[$];       // bytes waiting to be sent
	patched_t  patched_q[$];   // predicted results not yet seen
	int        items_left = 0; // queued bytes not yet accepted by the block
	int        errors = 0;

	// idle pattern per side: 0 none, 1 occasional waits, 2 a random wait drawn on every transaction
	int unsigned tx_style = 0, rx_style = 0;
	int unsigned tx_wait = 0, rx_wait = 0;
	int unsigned tx_sent = 0, rx_seen = 0;

	function automatic int unsigned draw_wait(input int unsigned style);
		case (style)
		0: return 0;
		1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
		default: return $urandom_range(0, 17);
		endcase
	endfunction

	// predicts the result of one accepted byte and advances the image state
	task automatic patch_rom_byte(input logic [7:0] din, input logic last);
		logic [rhpc_pkg::ADDR_BITS-1:0] a;
		logic [rhpc_pkg::ADDR_BITS-1:0] off;
		logic [7:0]                     b;
		patched_t                       r;
		a = rom_addr;
		b = din;
		r = '0;
		off = a - rhpc_pkg::ADDR_LOGO_LO;
		if (a >= rhpc_pkg::ADDR_LOGO_LO && a < rhpc_pkg::ADDR_LOGO_HI) begin
			if (live_cfg.logo_mode == rhpc_pkg::MODE_PLAIN)
				b = BOOT_LOGO[off[5:0]];
			else if (live_cfg.logo_mode == rhpc_pkg::MODE_INV)
				b = ~BOOT_LOGO[off[5:0]];
		end else begin
			case (a)
			rhpc_pkg::ADDR_CGB:
				if (live_cfg.flag_bits[FLAG_COMPAT] || live_cfg.flag_bits[FLAG_ONLY]) begin
					b = b | rhpc_pkg::CGB_COMPAT;
					if (live_cfg.flag_bits[FLAG_ONLY])
						b = b | rhpc_pkg::CGB_ONLY;
					// colour byte with stray low bits is a title clash
					r.conflict = |(b & rhpc_pkg::LOW_SIX_MASK);
				end
			rhpc_pkg::ADDR_NEWLIC_H: if (live_cfg.override_enable[OVR_NEWLIC])
				b = live_cfg.new_licensee_code[15:8];
			rhpc_pkg::ADDR_NEWLIC_L: if (live_cfg.override_enable[OVR_NEWLIC])
				b = live_cfg.new_licensee_code[7:0];
			rhpc_pkg::ADDR_SGB: if (live_cfg.flag_bits[FLAG_SGB])
				b = rhpc_pkg::SGB_VALUE;
			rhpc_pkg::ADDR_CART: if (live_cfg.override_enable[OVR_CART])
				b = live_cfg.override_bytes[7:0];
			rhpc_pkg::ADDR_ROMSIZE: if (live_cfg.override_enable[OVR_ROMSIZE])
				b = live_cfg.rom_size_code;
			rhpc_pkg::ADDR_RAMSIZE: if (live_cfg.override_enable[OVR_RAMSIZE])
				b = live_cfg.override_bytes[15:8];
			rhpc_pkg::ADDR_REGION: if (live_cfg.flag_bits[FLAG_REGION])
				b = rhpc_pkg::REGION_VALUE;
			rhpc_pkg::ADDR_OLDLIC: if (live_cfg.override_enable[OVR_OLDLIC])
				b = live_cfg.override_bytes[23:16];
			rhpc_pkg::ADDR_VERSION: if (live_cfg.override_enable[OVR_VERSION])
				b = live_cfg.override_bytes[31:24];
			rhpc_pkg::ADDR_HDRSUM: begin
				if (live_cfg.header_sum_mode == rhpc_pkg::MODE_PLAIN)
					b = hdr_sum;
				else if (live_cfg.header_sum_mode == rhpc_pkg::MODE_INV)
					b = ~hdr_sum;
			end
			default: ;
			endcase
		end

		// header sum runs over the patched bytes 0x134-0x14C
		if (a >= rhpc_pkg::ADDR_HDR_LO && a < rhpc_pkg::ADDR_HDRSUM)
			hdr_sum = hdr_sum - b - 8'd1;
		// global sum skips its own two bytes
		if (a != rhpc_pkg::ADDR_GSUM_H && a != rhpc_pkg::ADDR_GSUM_L)
			img_sum = img_sum + {8'd0, b};
		// counter sticks at the top address
		if (a == rhpc_pkg::ADDR_MAX)
			img_sat = 1'b1;
		else
			rom_addr = a + 1'b1;

		r.patched = b;
		if (last) begin
			if (live_cfg.global_sum_mode == rhpc_pkg::MODE_PLAIN) begin
				r.gsum = img_sum;
				r.sum_ok = 1'b1;
			end else if (live_cfg.global_sum_mode == rhpc_pkg::MODE_INV) begin
				r.gsum = ~img_sum;
				r.sum_ok = 1'b1;
			end
			if (img_sat)
				r.status = rhpc_pkg::STATUS_SAT;
			else if (a < rhpc_pkg::ADDR_GSUM_L)
				r.status = rhpc_pkg::STATUS_SHORT;
			else
				r.status = rhpc_pkg::STATUS_OK;
			// next image starts from address zero
			rom_addr = '0;
			hdr_sum = '0;
			img_sum = '0;
			img_sat = 1'b0;
		end
		patched_q.push_back(r);
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %h, got %h", $time, what, want, got);
		end
	endtask

	// input side: sends queued bytes, predicts each one as its transaction completes
	always @(posedge clk or negedge arst_n) begin : rom_driver
		rom_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				patch_rom_byte(s_tdata, s_tlast);
				items_left--;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait != 0) begin
					s_tvalid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (rom_q.size() != 0) begin
					nxt = rom_q.pop_front();
					s_tdata <= nxt.data;
					s_tlast <= nxt.last;
					s_tvalid <= 1'b1;
					// idle pattern changes every 50 transactions
					if (tx_sent % 50 == 0)
						tx_style = $urandom_range(0, 2);
					tx_sent++;
					tx_wait <= draw_wait(tx_style);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: random back-pressure, compares each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_monitor
		patched_t    r;
		int unsigned n;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			if (patched_q.size() == 0) begin
				errors++;
				$display("%0t ns: result expected none, got %h", $time, m_tdata);
			end else begin
				r = patched_q.pop_front();
				check_field("patched_byte", 32'(r.patched), 32'(m_tdata[7:0]));
				check_field("global_sum", 32'(r.gsum), 32'(m_tdata[23:8]));
				check_field("sum_valid", 32'(r.sum_ok), 32'(m_tdata[24]));
				check_field("colour_conflict", 32'(r.conflict), 32'(m_tdata[25]));
				check_field("image_status", 32'(r.status), 32'(m_tdata[27:26]));
				check_field("tdata padding", 32'd0, 32'(m_tdata[31:28]));
			end
			if (rx_seen % 50 == 0)
				rx_style = $urandom_range(0, 2);
			rx_seen++;
			n = draw_wait(rx_style);
			rx_wait <= n;
			m_tready <= (n == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= (rx_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic queue_byte(input logic [7:0] data, input logic last);
		rom_q.push_back('{last: last, data: data});
		items_left++;
	endtask

	// random image; the colour byte often gets a corner value
	task automatic queue_image(input int unsigned len);
		logic [7:0] d;
		logic [7:0] corner [6];
		corner = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'h3F, 8'hFF};
		for (int unsigned a = 0; a < len; a++) begin
			d = 8'($urandom);
			if (a == rhpc_pkg::ADDR_CGB && $urandom_range(0, 2) == 0)
				d = corner[$urandom_range(0, 5)];
			queue_byte(d, a == len - 1);
		end
	endtask

	// every byte accepted and every result seen, then a short settling pause for the pipeline
	task automatic wait_idle;
		while (items_left != 0 || patched_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// setup cycle then access cycle; called right after a rising edge
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register takes the value at this edge
		case (idx)
		rhpc_pkg::REG_LOGO_MODE:   live_cfg.logo_mode = value[1:0];
		rhpc_pkg::REG_HDRSUM_MODE: live_cfg.header_sum_mode = value[1:0];
		rhpc_pkg::REG_GSUM_MODE:   live_cfg.global_sum_mode = value[1:0];
		rhpc_pkg::REG_FLAG_BITS:   live_cfg.flag_bits = value[3:0];
		rhpc_pkg::REG_OVR_ENABLE:  live_cfg.override_enable = value[5:0];
		rhpc_pkg::REG_OVR_BYTES:   live_cfg.override_bytes = value;
		rhpc_pkg::REG_NEW_LIC:     live_cfg.new_licensee_code = value[15:0];
		rhpc_pkg::REG_ROM_SIZE:    live_cfg.rom_size_code = value[7:0];
		default: ;
		endcase
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		rhpc_pkg::cfg_t next_cfg;
		int unsigned    len;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: one-byte images at the byte extremes, then a two-byte image
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hA5, 1'b0);
		queue_byte(8'h5A, 1'b1);

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			next_cfg = '0;
			case (phase)
			0: begin
				// plain modes, colour compatible only
				next_cfg.logo_mode = rhpc_pkg::MODE_PLAIN;
				next_cfg.header_sum_mode = rhpc_pkg::MODE_PLAIN;
				next_cfg.global_sum_mode = rhpc_pkg::MODE_PLAIN;
				next_cfg.flag_bits[FLAG_COMPAT] = 1'b1;
			end
			1: begin
				// inverted modes, every flag and override at all-ones
				next_cfg.logo_mode = rhpc_pkg::MODE_INV;
				next_cfg.header_sum_mode = rhpc_pkg::MODE_INV;
				next_cfg.global_sum_mode = rhpc_pkg::MODE_INV;
				next_cfg.flag_bits = '1;
				next_cfg.override_enable = '1;
				next_cfg.override_bytes = '1;
				next_cfg.new_licensee_code = '1;
				next_cfg.rom_size_code = '1;
			end
			2: begin
				// undefined mode code, colour only, overrides writing zeros
				next_cfg.logo_mode = MODE_THREE;
				next_cfg.header_sum_mode = MODE_THREE;
				next_cfg.global_sum_mode = MODE_THREE;
				next_cfg.flag_bits[FLAG_ONLY] = 1'b1;
				next_cfg.override_enable = '1;
			end
			3: begin
				// values loaded but nothing enabled
				next_cfg.override_bytes = $urandom;
				next_cfg.new_licensee_code = 16'($urandom_range(0, 65535));
				next_cfg.rom_size_code = 8'($urandom_range(0, 255));
			end
			default: begin
				next_cfg.logo_mode = 2'($urandom_range(0, 3));
				next_cfg.header_sum_mode = 2'($urandom_range(0, 3));
				next_cfg.global_sum_mode = 2'($urandom_range(0, 3));
				next_cfg.flag_bits = 4'($urandom_range(0, 15));
				next_cfg.override_enable = 6'($urandom_range(0, 63));
				next_cfg.override_bytes = $urandom;
				next_cfg.new_licensee_code = 16'($urandom_range(0, 65535));
				next_cfg.rom_size_code = 8'($urandom_range(0, 255));
			end
			endcase
			write_reg(rhpc_pkg::REG_LOGO_MODE, 32'(next_cfg.logo_mode));
			write_reg(rhpc_pkg::REG_HDRSUM_MODE, 32'(next_cfg.header_sum_mode));
			write_reg(rhpc_pkg::REG_GSUM_MODE, 32'(next_cfg.global_sum_mode));
			write_reg(rhpc_pkg::REG_FLAG_BITS, 32'(next_cfg.flag_bits));
			write_reg(rhpc_pkg::REG_OVR_ENABLE, 32'(next_cfg.override_enable));
			write_reg(rhpc_pkg::REG_OVR_BYTES, next_cfg.override_bytes);
			write_reg(rhpc_pkg::REG_NEW_LIC, 32'(next_cfg.new_licensee_code));
			write_reg(rhpc_pkg::REG_ROM_SIZE, 32'(next_cfg.rom_size_code));

			// full image in the first two phases: exactly through 0x14F, then one byte short
			if (phase == 0) begin
				len = 32'(rhpc_pkg::ADDR_GSUM_L) + 1;
				queue_image(len);
			end else if (phase == 1) begin
				len = 32'(rhpc_pkg::ADDR_GSUM_L);
				queue_image(len);
			end

			// two short images of a few bytes
			for (int k = 0; k < 2; k++) begin
				len = $urandom_range(1, 8);
				queue_image(len);
			end
		end

		wait_idle();
		if (errors == 0)
			$display("rom_header_patch_checksum_top: match");
		else
			$display("rom_header_patch_checksum_top: mismatch");
		$finish;
	end

	// well beyond the slowest legal run
	initial begin : watchdog
		#20_000_000;
		$display("rom_header_patch_checksum_top: mismatch");
		$finish;
	end

endmodule
